[hw/rtl/lpsm_pkg.sv]
// Shared types, constants and helpers for the line prefix and substring matcher.
`timescale 1ns / 1ps

package lpsm_pkg;

  // Line terminator byte codes
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] NUL_BYTE     = 8'd0;

  // Window and pattern storage limits
  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned PAT_LEN_W    = 5;
  localparam int unsigned REPORT_W     = 16;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PREFIX_LOW       = 3'd0,
    CFG_PREFIX_HIGH      = 3'd1,
    CFG_PREFIX_LENGTH    = 3'd2,
    CFG_SUBSTRING_LOW    = 3'd3,
    CFG_SUBSTRING_HIGH   = 3'd4,
    CFG_SUBSTRING_LENGTH = 3'd5
  } cfg_reg_e;

  // Configuration register contents
  typedef struct packed {
    logic [CFG_DATA_W-1:0] prefix_low;
    logic [CFG_DATA_W-1:0] prefix_high;
    logic [PAT_LEN_W-1:0]  prefix_length;
    logic [CFG_DATA_W-1:0] substring_low;
    logic [CFG_DATA_W-1:0] substring_high;
    logic [PAT_LEN_W-1:0]  substring_length;
  } cfg_t;

  // One line result
  typedef struct packed {
    logic                prefix_hit;
    logic                substring_hit;
    logic [REPORT_W-1:0] line_length;
    logic                terminator_kind;
  } result_t;

  // Byte k of a 16-byte pattern held as two 64-bit halves
  function automatic logic [7:0] pattern_byte(input logic [CFG_DATA_W-1:0] lo,
                                              input logic [CFG_DATA_W-1:0] hi,
                                              input logic [3:0] k);
    logic [2*CFG_DATA_W-1:0] both;
    both = {hi, lo};
    return both[{k, 3'b000} +: 8];
  endfunction

endpackage

[hw/rtl/lpsm_match_core.sv]
// Per-line state (byte window, length count, match flags) and the match logic for one byte.
`timescale 1ns / 1ps

module lpsm_match_core #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpsm_pkg::cfg_t        cfg_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  advance_i,
  output logic                  is_term_o,
  output lpsm_pkg::result_t     result_o
);

  localparam int unsigned EXT_W = (LENGTH_BITS > lpsm_pkg::REPORT_W) ?
                                  LENGTH_BITS : lpsm_pkg::REPORT_W;

  logic [PATTERN_MAX-1:0][7:0] win_q;
  logic [PATTERN_MAX-1:0][7:0] win_new;
  logic [LENGTH_BITS-1:0]      count_q;
  logic [LENGTH_BITS-1:0]      count_new;
  logic                        pok_q;
  logic                        pok_new;
  logic                        sfound_q;
  logic                        smatch;
  logic                        pcheck;
  logic                        plen_ok;
  logic                        slen_ok;
  logic [7:0]                  pbyte;
  logic [LENGTH_BITS:0]        count_plus;
  logic [EXT_W-1:0]            count_ext;
  logic [PATTERN_MAX-1:0]      pos_ok;

  assign is_term_o = (data_byte_i == lpsm_pkg::NEWLINE_BYTE) ||
                     (data_byte_i == lpsm_pkg::NUL_BYTE);

  // A pattern length is usable when nonzero and within the pattern storage
  assign plen_ok = (cfg_i.prefix_length != '0) &&
                   (cfg_i.prefix_length <= lpsm_pkg::PAT_LEN_W'(PATTERN_MAX));
  assign slen_ok = (cfg_i.substring_length != '0) &&
                   (cfg_i.substring_length <= lpsm_pkg::PAT_LEN_W'(PATTERN_MAX));

  // Prefix byte check at the current line position, terminator included
  assign pcheck = (count_q < LENGTH_BITS'(cfg_i.prefix_length)) &&
                  (count_q < LENGTH_BITS'(lpsm_pkg::WINDOW_DEPTH));
  assign pbyte  = lpsm_pkg::pattern_byte(cfg_i.prefix_low, cfg_i.prefix_high,
                                         count_q[3:0]);
  assign pok_new = pok_q && !(pcheck && (data_byte_i != pbyte));

  // Window after shifting in a body byte, newest at position 0
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_win
    if (p == 0) begin : g_head
      assign win_new[p] = data_byte_i;
    end else begin : g_tail
      assign win_new[p] = win_q[p-1];
    end
  end

  // Saturating body length
  assign count_new = (count_q == '1) ? count_q : count_q + 1'b1;

  // Substring test: window position p holds pattern byte length-1-p
  always_comb begin
    logic [lpsm_pkg::PAT_LEN_W-1:0] sidx;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      sidx = cfg_i.substring_length - lpsm_pkg::PAT_LEN_W'(1) -
             lpsm_pkg::PAT_LEN_W'(p);
      pos_ok[p] = (lpsm_pkg::PAT_LEN_W'(p) >= cfg_i.substring_length) ||
                  (win_new[p] == lpsm_pkg::pattern_byte(cfg_i.substring_low,
                                                        cfg_i.substring_high,
                                                        sidx[3:0]));
    end
  end

  assign smatch = slen_ok && (&pos_ok) &&
                  (count_new >= LENGTH_BITS'(cfg_i.substring_length));

  // Line result, valid when the byte is a terminator
  assign count_plus = {1'b0, count_q} + 1'b1;
  assign count_ext  = EXT_W'(count_q);

  always_comb begin
    result_o.prefix_hit    = pok_new && plen_ok &&
                             (count_plus >= (LENGTH_BITS + 1)'(cfg_i.prefix_length));
    result_o.substring_hit = sfound_q;
    result_o.line_length   = (count_ext > EXT_W'({lpsm_pkg::REPORT_W{1'b1}})) ?
                             {lpsm_pkg::REPORT_W{1'b1}} :
                             count_ext[lpsm_pkg::REPORT_W-1:0];
    result_o.terminator_kind = (data_byte_i == lpsm_pkg::NUL_BYTE);
  end

  // Line control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pok_q    <= 1'b1;
      sfound_q <= 1'b0;
    end else if (advance_i) begin
      if (is_term_o) begin
        count_q  <= '0;
        pok_q    <= 1'b1;
        sfound_q <= 1'b0;
      end else begin
        count_q  <= count_new;
        pok_q    <= pok_new;
        sfound_q <= sfound_q | smatch;
      end
    end
  end

  // Byte window; stale bytes are never compared because of the length gate
  always_ff @(posedge clk_i) begin
    if (advance_i && !is_term_o) begin
      win_q <= win_new;
    end
  end

`ifndef SYNTHESIS
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && is_term_o |=> (count_q == '0) && pok_q && !sfound_q)
    else $error("line state not cleared after terminator");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !is_term_o && (count_q != '1) |=> count_q == $past(count_q) + 1'b1)
    else $error("line length did not advance by one");

  a_found_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sfound_q && !(advance_i && is_term_o) |=> sfound_q)
    else $error("substring flag dropped inside a line");
`endif

endmodule

[hw/rtl/line_prefix_substring_matcher_unit.sv]
// Top level of the line prefix and substring matcher: handshakes, config registers, result register.
`timescale 1ns / 1ps

// Takes one text byte per transaction and, for every newline or NUL, returns one result with
// the prefix and substring hit flags, the saturated body length and the terminator kind.
// Bytes that are not terminators produce nothing. The block sustains one byte per cycle while no
// terminator is held back: a byte sits in the input register while the match logic updates the
// line state, and a terminator's result is then loaded into the output register. Input backpressure
// comes only from a terminator that finds the output register still full and not being taken.
// Configuration is written through the plain write port; the user must write it only while no byte is in flight.
module line_prefix_substring_matcher_unit #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [lpsm_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [lpsm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // byte input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           data_byte_i,
  // result output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 prefix_hit_o,
  output logic                                 substring_hit_o,
  output logic [lpsm_pkg::REPORT_W-1:0]        line_length_o,
  output logic                                 terminator_kind_o
);

  lpsm_pkg::cfg_t    cfg_q;
  lpsm_pkg::result_t core_res;
  lpsm_pkg::result_t res_q;
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_term;
  logic              s1_adv;
  logic              out_free;
  logic              out_load;
  logic              out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (lpsm_pkg::cfg_reg_e'(cfg_index_i))
        lpsm_pkg::CFG_PREFIX_LOW:       cfg_q.prefix_low       <= cfg_data_i;
        lpsm_pkg::CFG_PREFIX_HIGH:      cfg_q.prefix_high      <= cfg_data_i;
        lpsm_pkg::CFG_PREFIX_LENGTH:
          cfg_q.prefix_length <= cfg_data_i[lpsm_pkg::PAT_LEN_W-1:0];
        lpsm_pkg::CFG_SUBSTRING_LOW:    cfg_q.substring_low    <= cfg_data_i;
        lpsm_pkg::CFG_SUBSTRING_HIGH:   cfg_q.substring_high   <= cfg_data_i;
        lpsm_pkg::CFG_SUBSTRING_LENGTH:
          cfg_q.substring_length <= cfg_data_i[lpsm_pkg::PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: body bytes always move on, terminators need a free result slot
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_term || out_free);
  assign out_load   = s1_adv && s1_term;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
    end
  end

  lpsm_match_core #(
    .PATTERN_MAX (PATTERN_MAX),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .data_byte_i (s1_byte_q),
    .advance_i   (s1_adv),
    .is_term_o   (s1_term),
    .result_o    (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign prefix_hit_o      = res_q.prefix_hit;
  assign substring_hit_o   = res_q.substring_hit;
  assign line_length_o     = res_q.line_length;
  assign terminator_kind_o = res_q.terminator_kind;

`ifndef SYNTHESIS
  a_body_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_term |-> s1_adv)
    else $error("body byte held in input register");

  a_term_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_term && out_valid_q && !out_ready_i |-> !in_ready_o && !s1_adv)
    else $error("terminator advanced over an untaken result");

  a_result_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(s1_valid_q && s1_term))
    else $error("result appeared without a terminator");
`endif

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the line prefix and substring matcher unit.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned BYTES_PER_SETTING = 40;

  // Clock, reset and block ports
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  lpsm_pkg::cfg_reg_e            cfg_index_i = lpsm_pkg::CFG_PREFIX_LOW;
  logic [lpsm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    data_byte_i = 8'd0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          prefix_hit_o;
  logic                          substring_hit_o;
  logic [lpsm_pkg::REPORT_W-1:0] line_length_o;
  logic                          terminator_kind_o;

  // Shadow copy of the configuration registers
  logic [lpsm_pkg::CFG_DATA_W-1:0] pfx_lo = '0;
  logic [lpsm_pkg::CFG_DATA_W-1:0] pfx_hi = '0;
  logic [lpsm_pkg::PAT_LEN_W-1:0]  pfx_len = '0;
  logic [lpsm_pkg::CFG_DATA_W-1:0] sub_lo = '0;
  logic [lpsm_pkg::CFG_DATA_W-1:0] sub_hi = '0;
  logic [lpsm_pkg::PAT_LEN_W-1:0]  sub_len = '0;

  // Predicted line state
  logic [7:0]          recent_bytes [lpsm_pkg::WINDOW_DEPTH];
  logic [15:0]         body_count = '0;
  bit                  prefix_ok = 1'b1;
  bit                  substring_seen = 1'b0;

  // Pending text bytes and expected line reports
  logic [7:0]          text_bytes_q [$];
  lpsm_pkg::result_t   expected_lines_q [$];

  int unsigned         sender_idle_pct = 0;
  int unsigned         receiver_idle_pct = 0;
  int unsigned         hold_reqs = 0;
  int unsigned         hold_done = 0;
  int unsigned         hold_left = 0;
  int unsigned         cycles = 0;
  int unsigned         bytes_queued = 0;
  int unsigned         errors = 0;
  int unsigned         lines_checked = 0;
  int unsigned         prefix_hits = 0;
  int unsigned         substring_hits = 0;
  int unsigned         nul_lines = 0;

  line_prefix_substring_matcher_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .prefix_hit_o      (prefix_hit_o),
    .substring_hit_o   (substring_hit_o),
    .line_length_o     (line_length_o),
    .terminator_kind_o (terminator_kind_o)
  );

  always #5 clk_i = ~clk_i;

  // Byte k of a pattern stored as two 64-bit halves
  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int k);
    logic [127:0] shifted;
    shifted = {hi, lo} >> (8 * k);
    return shifted[7:0];
  endfunction

  function automatic bit pattern_enabled(input logic [lpsm_pkg::PAT_LEN_W-1:0] n);
    return n != 0 && n <= lpsm_pkg::WINDOW_DEPTH;
  endfunction

  function automatic void reset_line();
    foreach (recent_bytes[j]) recent_bytes[j] = 8'd0;
    body_count = '0;
    prefix_ok = 1'b1;
    substring_seen = 1'b0;
  endfunction

  // Advance the line state by one accepted byte; a terminator yields a line report
  function automatic void advance_line_state(input logic [7:0] b);
    lpsm_pkg::result_t exp_line;
    int n;
    bit all_equal;
    if (int'(body_count) < int'(pfx_len) && body_count < lpsm_pkg::WINDOW_DEPTH) begin
      if (b != pat_byte(pfx_lo, pfx_hi, int'(body_count))) prefix_ok = 1'b0;
    end
    if (b == lpsm_pkg::NEWLINE_BYTE || b == lpsm_pkg::NUL_BYTE) begin
      exp_line.prefix_hit = prefix_ok && pattern_enabled(pfx_len) &&
                            (int'(body_count) + 1 >= int'(pfx_len));
      exp_line.substring_hit = substring_seen;
      exp_line.line_length = body_count;
      exp_line.terminator_kind = (b == lpsm_pkg::NUL_BYTE);
      expected_lines_q.push_back(exp_line);
      reset_line();
      return;
    end
    for (int j = lpsm_pkg::WINDOW_DEPTH - 1; j > 0; j--) recent_bytes[j] = recent_bytes[j-1];
    recent_bytes[0] = b;
    if (body_count != 16'hFFFF) body_count = body_count + 1'b1;
    n = int'(sub_len);
    if (pattern_enabled(sub_len) && int'(body_count) >= n) begin
      all_equal = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (recent_bytes[n-1-j] != pat_byte(sub_lo, sub_hi, j)) all_equal = 1'b0;
      end
      if (all_equal) substring_seen = 1'b1;
    end
  endfunction

  // Compare one accepted report with the oldest expectation
  function automatic void check_line_report();
    lpsm_pkg::result_t exp_line;
    if (expected_lines_q.size() == 0) begin
      $error("unexpected line report: length %0d", line_length_o);
      errors++;
      return;
    end
    exp_line = expected_lines_q.pop_front();
    lines_checked++;
    if (prefix_hit_o) prefix_hits++;
    if (substring_hit_o) substring_hits++;
    if (terminator_kind_o) nul_lines++;
    if (prefix_hit_o !== exp_line.prefix_hit) begin
      $error("prefix_hit: expected %0d, actual %0d", exp_line.prefix_hit, prefix_hit_o);
      errors++;
    end
    if (substring_hit_o !== exp_line.substring_hit) begin
      $error("substring_hit: expected %0d, actual %0d", exp_line.substring_hit,
             substring_hit_o);
      errors++;
    end
    if (line_length_o !== exp_line.line_length) begin
      $error("line_length: expected %0d, actual %0d", exp_line.line_length, line_length_o);
      errors++;
    end
    if (terminator_kind_o !== exp_line.terminator_kind) begin
      $error("terminator_kind: expected %0d, actual %0d", exp_line.terminator_kind,
             terminator_kind_o);
      errors++;
    end
  endfunction

  // Byte driver: offers the next queued byte, predicts on each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'd0;
    end else begin
      if (in_valid_i && in_ready_o) advance_line_state(data_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (text_bytes_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          data_byte_i <= text_bytes_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Report monitor with random stalls and requested long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_line_report();
      if (hold_done != hold_reqs) begin
        hold_done <= hold_done + 1;
        hold_left <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly a small alphabet so that patterns recur by chance
  function automatic logic [7:0] pick_char(input bit allow_term);
    int unsigned r;
    logic [7:0] c;
    r = $urandom_range(0, 19);
    if (r < 6) c = "a";
    else if (r < 10) c = "b";
    else if (r < 13) c = "c";
    else if (r == 13) c = 8'hFF;
    else if (r == 14) c = lpsm_pkg::NEWLINE_BYTE;
    else if (r == 15) c = lpsm_pkg::NUL_BYTE;
    else c = 8'($urandom_range(1, 255));
    if (!allow_term && (c == lpsm_pkg::NEWLINE_BYTE || c == lpsm_pkg::NUL_BYTE)) c = "c";
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    text_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic write_reg(input lpsm_pkg::cfg_reg_e idx,
                           input logic [lpsm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lpsm_pkg::CFG_PREFIX_LOW:       pfx_lo = val;
      lpsm_pkg::CFG_PREFIX_HIGH:      pfx_hi = val;
      lpsm_pkg::CFG_PREFIX_LENGTH:    pfx_len = val[lpsm_pkg::PAT_LEN_W-1:0];
      lpsm_pkg::CFG_SUBSTRING_LOW:    sub_lo = val;
      lpsm_pkg::CFG_SUBSTRING_HIGH:   sub_hi = val;
      lpsm_pkg::CFG_SUBSTRING_LENGTH: sub_len = val[lpsm_pkg::PAT_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Wait until every byte is taken and every report has come, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (text_bytes_q.size() != 0 || in_valid_i || expected_lines_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random patterns; oversized lengths when asked
  task automatic random_setting(input bit oversize);
    logic [127:0] pfx_pat;
    logic [127:0] sub_pat;
    int unsigned plen;
    int unsigned slen;
    for (int k = 0; k < 16; k++) begin
      pfx_pat[8*k +: 8] = pick_char(1'b1);
      sub_pat[8*k +: 8] = pick_char(1'b1);
    end
    if (oversize) begin
      plen = $urandom_range(17, 31);
      slen = $urandom_range(17, 31);
    end else begin
      plen = $urandom_range(0, 16);
      slen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 5);
    end
    write_reg(lpsm_pkg::CFG_PREFIX_LOW, pfx_pat[63:0]);
    write_reg(lpsm_pkg::CFG_PREFIX_HIGH, pfx_pat[127:64]);
    write_reg(lpsm_pkg::CFG_PREFIX_LENGTH, 64'(plen));
    write_reg(lpsm_pkg::CFG_SUBSTRING_LOW, sub_pat[63:0]);
    write_reg(lpsm_pkg::CFG_SUBSTRING_HIGH, sub_pat[127:64]);
    write_reg(lpsm_pkg::CFG_SUBSTRING_LENGTH, 64'(slen));
  endtask

  // One line: random body, often seeded with the prefix and the substring
  task automatic push_line();
    logic [7:0] body [$];
    logic [7:0] term;
    int n;
    int pos;
    int plen;
    int slen;
    bit with_prefix;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    plen = int'(pfx_len);
    slen = int'(sub_len);
    for (int j = 0; j < n; j++) body.push_back(pick_char(1'b0));
    with_prefix = 1'($urandom_range(0, 1));
    if (with_prefix) begin
      for (int j = 0; j < plen && j < 16 && j < n; j++) body[j] = pat_byte(pfx_lo, pfx_hi, j);
    end
    if (slen > 0 && slen <= 16 && slen <= n && $urandom_range(0, 1) == 1) begin
      pos = $urandom_range(0, n - slen);
      for (int j = 0; j < slen; j++) body[pos+j] = pat_byte(sub_lo, sub_hi, j);
    end
    // occasional damage to a seeded line
    if (n > 0 && $urandom_range(0, 4) == 0) body[$urandom_range(0, n - 1)] = pick_char(1'b0);
    term = $urandom_range(0, 1) ? lpsm_pkg::NEWLINE_BYTE : lpsm_pkg::NUL_BYTE;
    // prefix that reaches into the terminator byte
    if (with_prefix && plen == n + 1 && plen <= 16 && $urandom_range(0, 1) == 1)
      term = pat_byte(pfx_lo, pfx_hi, n);
    foreach (body[j]) push_byte(body[j]);
    push_byte(term);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Stimulus sequence
  initial begin
    int unsigned mark;
    reset_line();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    sender_idle_pct = 14;
    receiver_idle_pct = 83;

    // Patterns at reset are empty: nothing may match
    push_byte("a");
    push_byte(lpsm_pkg::NEWLINE_BYTE);
    push_byte(lpsm_pkg::NUL_BYTE);
    wait_drained();

    // Prefix "ab" plus newline, substring "b": full hit, short line, wrong terminator
    write_reg(lpsm_pkg::CFG_PREFIX_LOW, {40'd0, lpsm_pkg::NEWLINE_BYTE, 8'h62, 8'h61});
    write_reg(lpsm_pkg::CFG_PREFIX_HIGH, 64'd0);
    write_reg(lpsm_pkg::CFG_PREFIX_LENGTH, 64'd3);
    write_reg(lpsm_pkg::CFG_SUBSTRING_LOW, 64'h62);
    write_reg(lpsm_pkg::CFG_SUBSTRING_HIGH, 64'd0);
    write_reg(lpsm_pkg::CFG_SUBSTRING_LENGTH, 64'd1);
    push_byte("a");
    push_byte("b");
    push_byte(lpsm_pkg::NEWLINE_BYTE);
    push_byte("a");
    push_byte(lpsm_pkg::NEWLINE_BYTE);
    push_byte("a");
    push_byte("b");
    push_byte(lpsm_pkg::NUL_BYTE);
    wait_drained();

    // Longest patterns, all ones
    write_reg(lpsm_pkg::CFG_PREFIX_LOW, '1);
    write_reg(lpsm_pkg::CFG_PREFIX_HIGH, '1);
    write_reg(lpsm_pkg::CFG_PREFIX_LENGTH, 64'd16);
    write_reg(lpsm_pkg::CFG_SUBSTRING_LOW, '1);
    write_reg(lpsm_pkg::CFG_SUBSTRING_HIGH, '1);
    write_reg(lpsm_pkg::CFG_SUBSTRING_LENGTH, 64'd16);
    repeat (16) push_byte(8'hFF);
    push_byte(lpsm_pkg::NUL_BYTE);

    // Random part in three idle modes, three settings each
    for (int mode = 0; mode < 3; mode++) begin
      for (int s = 0; s < 3; s++) begin
        wait_drained();
        if (mode == 1) begin
          sender_idle_pct = 83;
          receiver_idle_pct = 14;
        end else if (mode == 2) begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
        random_setting(mode == 1 && s == 0);
        // long receiver hold-off while short lines keep arriving
        if (mode == 2 && s == 1) begin
          hold_reqs = hold_reqs + 1;
          for (int j = 0; j < 40; j++) begin
            if (j % 2 == 0) push_byte("x");
            push_byte((j % 2 == 0) ? lpsm_pkg::NUL_BYTE : lpsm_pkg::NEWLINE_BYTE);
          end
        end
        mark = bytes_queued;
        while (bytes_queued - mark < BYTES_PER_SETTING) begin
          if ($urandom_range(0, 9) == 0) push_noise();
          else push_line();
        end
        // leave a line open so the next setting lands mid-line
        if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 3)) push_byte(pick_char(1'b0));
        // sender pause until every report is back, same setting
        if (mode == 0 && s == 1) begin
          wait_drained();
          repeat (20) push_line();
        end
      end
    end
    wait_drained();

    $display("Sent %0d bytes; checked %0d line reports (%0d NUL-ended).",
             bytes_queued, lines_checked, nul_lines);
    $display("Prefix hits %0d, substring hits %0d, over three idle modes and twelve settings.",
             prefix_hits, substring_hits);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
